>>> rtl/core/ctfa_pkg.sv
// ----------------------------------------------------------------------------
// ctfa_pkg
// Shared types and codes of the cluster table file allocator.
// ----------------------------------------------------------------------------
package ctfa_pkg;

	// Transaction codes.
	localparam logic [2:0] OP_NEW    = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_COPY   = 3'd2;
	localparam logic [2:0] OP_RENAME = 3'd3;
	localparam logic [2:0] OP_MODIFY = 3'd4;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EXISTS  = 3'd1;
	localparam logic [2:0] ST_MISSING = 3'd2;
	localparam logic [2:0] ST_TARGET  = 3'd3;
	localparam logic [2:0] ST_NOSPACE = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;
	localparam logic [2:0] ST_LARGE   = 3'd6;

	// Field widths and reset values.
	localparam int SIZE_W = 24;
	localparam int CB_W   = 16;
	localparam int DSR_W  = CB_W + 1;
	localparam int QN_W   = SIZE_W + 1;
	localparam logic [CB_W-1:0]   CB_RESET    = 16'd512;
	localparam logic [SIZE_W-1:0] SIZE0_RESET = 24'd512;

	// What the commit step writes back into the file table.
	typedef enum logic [2:0] {
		CM_NONE,
		CM_CREATE,
		CM_MODIFY,
		CM_DELETE,
		CM_RENAME
	} ctfa_commit_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FSCAN,
		S_WAIT,
		S_DECIDE,
		S_DIV,
		S_CHECK,
		S_ALLOC,
		S_FREE,
		S_COPY,
		S_COMMIT,
		S_DONE
	} ctfa_state_t;

endpackage

>>> rtl/core/cluster_table_file_allocator.sv
// ----------------------------------------------------------------------------
// cluster_table_file_allocator
// FAT style file store with first fit cluster allocation.
// ----------------------------------------------------------------------------
// A transaction beat is taken when start is high and busy is low; operation,
// file_id, other_id and file_size are sampled at that edge. The block then
// works alone on the beat and raises done for exactly one cycle with status,
// clusters_allocated, first_cluster, clusters_freed and free_clusters. The
// receiver cannot stall: the result beat is gone after that cycle.
// cluster_bytes is to be written with cluster_bytes_we while the block is
// idle; the user must keep to this, as the block does not enforce it. After
// reset a clearing pass initializes the cluster memory; busy is high during
// it, while cluster_bytes writes are taken. Steps of one transaction: a file
// table scan, the shared divider for the cluster count and a check of it,
// then a first fit scan of the cluster memory (one cluster read a cycle), a
// release of the old clusters, a list copy, and a commit and report. No new
// beat is taken until the last one is reported; failed transactions finish
// after the scan or the divider.
// ----------------------------------------------------------------------------
module cluster_table_file_allocator import ctfa_pkg::*; #(
	parameter int NUM_CLUSTERS      = 4096,
	parameter int MAX_FILES         = 64,
	parameter int MAX_FILE_CLUSTERS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cluster_bytes_we,
	input  logic [15:0] cluster_bytes,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [15:0] file_id,
	input  logic [15:0] other_id,
	input  logic [23:0] file_size,
	output logic        done,
	output logic [2:0]  status,
	output logic [6:0]  clusters_allocated,
	output logic [11:0] first_cluster,
	output logic [6:0]  clusters_freed,
	output logic [12:0] free_clusters
);

	localparam int CW = $clog2(NUM_CLUSTERS);
	localparam int FW = $clog2(NUM_CLUSTERS + 1);
	localparam int SW = $clog2(MAX_FILES);
	localparam int KW = (MAX_FILE_CLUSTERS > 1) ? $clog2(MAX_FILE_CLUSTERS) : 1;
	localparam int NW = $clog2(MAX_FILE_CLUSTERS + 1);
	localparam int LD = MAX_FILES * MAX_FILE_CLUSTERS;
	localparam int LW = $clog2(LD);

	ctfa_state_t state_q, state_d;

	// Memories: cluster in-use bits, per-file cluster lists, allocation scratch
	// list and the file table words.
	logic              used_mem [NUM_CLUSTERS];
	logic [CW-1:0]     list_mem [LD];
	logic [CW-1:0]     scr_mem  [MAX_FILE_CLUSTERS];
	logic [15:0]       ids_mem  [MAX_FILES];
	logic [SIZE_W-1:0] size_mem [MAX_FILES];
	logic [NW-1:0]     cnt_mem  [MAX_FILES];
	logic [MAX_FILES-1:0] valid_q;

	logic              used_rd_q;
	logic [CW-1:0]     list_rd_q;
	logic [CW-1:0]     scr_rd_q;
	logic [15:0]       id_rd_q;
	logic              val_rd_q;
	logic [SIZE_W-1:0] sz_rd_q;
	logic [NW-1:0]     cnt_rd_q;

	logic          used_we, used_wd;
	logic [CW-1:0] used_wa, used_ra;
	logic          list_we;
	logic [LW-1:0] list_wa, list_ra;
	logic [CW-1:0] list_wd;
	logic          scr_we;
	logic          ids_we, sc_we;
	logic [SW-1:0] tab_wa;
	logic [15:0]   ids_wd;
	logic [SIZE_W-1:0] sz_wd;
	logic [NW-1:0] cn_wd;

	// Configuration and captured transaction.
	logic [CB_W-1:0]   cb_q;
	logic [2:0]        op_q;
	logic [15:0]       fid_q, oid_q;
	logic [SIZE_W-1:0] size_q;

	// Sequencer counters and stage registers.
	logic [CW-1:0] clr_q;
	logic [SW:0]   sidx_q;
	logic [SW-1:0] sidx_s1;
	logic          sv_s1;
	logic          ff_q, fo_q, fe_q;
	logic [SW-1:0] sf_q, se_q;
	logic [CW-1:0] ca_q, ca_s1;
	logic          av_s1;
	logic [NW-1:0] got_q;
	logic [NW-1:0] fk_q, fd_q;
	logic          fv_s1, fv_s2;
	logic [CW-1:0] fc_s2;
	logic [NW-1:0] ck_q, ck_s1;
	logic          cv_s1;

	// Transaction bookkeeping and result.
	ctfa_commit_t      cm_q;
	logic [SW-1:0]     tgt_q;
	logic [15:0]       new_id_q;
	logic [SIZE_W-1:0] new_size_q;
	logic [NW-1:0]     n_q;
	logic [2:0]        status_q;
	logic [CW-1:0]     first_q;
	logic [NW-1:0]     freed_q;
	logic [FW-1:0]     free_q;
	logic              alloc_ok_q;

	// Shared divider.
	logic              div_start, div_done;
	logic [SIZE_W-1:0] div_dividend;
	logic [QN_W-1:0]   n_full;
	logic [DSR_W-1:0]  divisor;

	assign divisor = (cb_q == '0) ? {1'b1, {CB_W{1'b0}}} : {1'b0, cb_q};

	ctfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (divisor),
		.done     (div_done),
		.clusters (n_full)
	);

	// Stage conditions.
	logic accept, scan_last, take, alloc_exit, free_issue, free_exit, copy_issue, copy_exit;
	logic m_f, m_o, e_s;

	assign accept     = start && (state_q == S_IDLE);
	assign scan_last  = sv_s1 && (sidx_s1 == SW'(MAX_FILES - 1));
	assign m_f        = sv_s1 && val_rd_q && (id_rd_q == fid_q);
	assign m_o        = sv_s1 && val_rd_q && (id_rd_q == oid_q);
	assign e_s        = sv_s1 && !val_rd_q;
	assign take       = av_s1 && !used_rd_q && (got_q != n_q);
	assign alloc_exit = take && ((got_q + NW'(1)) == n_q);
	assign free_issue = (fk_q < cnt_rd_q);
	assign free_exit  = (cnt_rd_q == '0) || (fv_s2 && ((fd_q + NW'(1)) == cnt_rd_q));
	assign copy_issue = (ck_q < n_q);
	assign copy_exit  = cv_s1 && ((ck_s1 + NW'(1)) == n_q);

	// Decision after the file table scan.
	ctfa_state_t       dec_next;
	logic [2:0]        dec_status;
	ctfa_commit_t      dec_cm;
	logic [SW-1:0]     dec_tgt;
	logic [15:0]       dec_id;
	logic [SIZE_W-1:0] dec_size;

	always_comb begin
		dec_next   = S_DONE;
		dec_status = ST_OK;
		dec_cm     = CM_NONE;
		dec_tgt    = se_q;
		dec_id     = fid_q;
		dec_size   = size_q;
		unique case (op_q)
			OP_NEW: begin
				if (ff_q) begin
					dec_status = ST_EXISTS;
				end else begin
					dec_cm   = CM_CREATE;
					dec_next = S_DIV;
				end
			end
			OP_DELETE: begin
				if (!ff_q) begin
					dec_status = ST_MISSING;
				end else begin
					dec_cm   = CM_DELETE;
					dec_tgt  = sf_q;
					dec_next = S_FREE;
				end
			end
			OP_COPY, OP_RENAME: begin
				if (fo_q) begin
					dec_status = ST_TARGET;
				end else if (!ff_q) begin
					dec_status = ST_MISSING;
				end else if (op_q == OP_RENAME) begin
					dec_cm   = CM_RENAME;
					dec_tgt  = sf_q;
					dec_id   = oid_q;
					dec_next = S_COMMIT;
				end else begin
					dec_cm   = CM_CREATE;
					dec_id   = oid_q;
					dec_size = sz_rd_q;
					dec_next = S_DIV;
				end
			end
			OP_MODIFY: begin
				dec_next = S_DIV;
				if (ff_q) begin
					dec_cm  = CM_MODIFY;
					dec_tgt = sf_q;
				end else begin
					dec_cm = CM_CREATE;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	// Space checks once the cluster count is known.
	logic       chk_fail;
	logic [2:0] chk_status;

	always_comb begin
		chk_fail   = 1'b1;
		chk_status = ST_OK;
		priority if (n_full > QN_W'(MAX_FILE_CLUSTERS)) begin
			chk_status = ST_LARGE;
		end else if ((cm_q == CM_CREATE) && !fe_q) begin
			chk_status = ST_FULL;
		end else if (n_full > QN_W'(free_q)) begin
			chk_status = ST_NOSPACE;
		end else begin
			chk_fail = 1'b0;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = dec_size;
		used_we      = 1'b0;
		used_wa      = ca_s1;
		used_wd      = 1'b1;
		used_ra      = ca_q;
		list_we      = 1'b0;
		list_wa      = LW'(tgt_q) * LW'(MAX_FILE_CLUSTERS) + LW'(ck_s1);
		list_wd      = scr_rd_q;
		list_ra      = LW'(sf_q) * LW'(MAX_FILE_CLUSTERS) + LW'(fk_q);
		scr_we       = 1'b0;
		ids_we       = 1'b0;
		sc_we        = 1'b0;
		tab_wa       = tgt_q;
		ids_wd       = new_id_q;
		sz_wd        = new_size_q;
		cn_wd        = n_q;
		unique case (state_q)
			S_CLEAR: begin
				used_we = 1'b1;
				used_wa = clr_q;
				used_wd = (clr_q == '0);
				list_wa = '0;
				list_wd = '0;
				list_we = (clr_q == '0);
				tab_wa  = SW'(clr_q);
				ids_wd  = 16'(clr_q);
				sz_wd   = (clr_q == '0) ? SIZE0_RESET : '0;
				cn_wd   = NW'(clr_q == '0);
				ids_we  = (clr_q < CW'(2));
				sc_we   = (clr_q < CW'(2));
				if (clr_q == CW'(NUM_CLUSTERS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_FSCAN;
				end
			end
			S_FSCAN: begin
				if (scan_last) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d   = dec_next;
				div_start = (dec_next == S_DIV);
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (chk_fail) begin
					state_d = S_DONE;
				end else if (n_full == '0) begin
					state_d = (cm_q == CM_MODIFY) ? S_FREE : S_COMMIT;
				end else begin
					state_d = S_ALLOC;
				end
			end
			S_ALLOC: begin
				used_we = take;
				scr_we  = take;
				if (alloc_exit) begin
					state_d = (cm_q == CM_MODIFY) ? S_FREE : S_COPY;
				end
			end
			S_FREE: begin
				used_ra = list_rd_q;
				used_wa = fc_s2;
				used_wd = 1'b0;
				used_we = fv_s2 && used_rd_q;
				if (free_exit) begin
					state_d = ((cm_q == CM_DELETE) || (n_q == '0)) ? S_COMMIT : S_COPY;
				end
			end
			S_COPY: begin
				list_we = cv_s1;
				if (copy_exit) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				ids_we  = (cm_q == CM_CREATE) || (cm_q == CM_RENAME);
				sc_we   = (cm_q == CM_CREATE) || (cm_q == CM_MODIFY);
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Memories with registered read data.
	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_wa] <= used_wd;
		end
		used_rd_q <= used_mem[used_ra];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_wa] <= list_wd;
		end
		list_rd_q <= list_mem[list_ra];
	end

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[got_q[KW-1:0]] <= ca_s1;
		end
		scr_rd_q <= scr_mem[ck_q[KW-1:0]];
	end

	// The valid flag of a slot is read alongside its id.
	always_ff @(posedge clk) begin
		if (ids_we) begin
			ids_mem[tab_wa] <= ids_wd;
		end
		id_rd_q  <= ids_mem[sidx_q[SW-1:0]];
		val_rd_q <= valid_q[sidx_q[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sc_we) begin
			size_mem[tab_wa] <= sz_wd;
			cnt_mem[tab_wa]  <= cn_wd;
		end
		sz_rd_q  <= size_mem[sf_q];
		cnt_rd_q <= cnt_mem[sf_q];
	end

	// Sequencer datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q       <= CB_RESET;
			valid_q    <= {{(MAX_FILES - 2){1'b0}}, 2'b11};
			free_q     <= FW'(NUM_CLUSTERS - 1);
			clr_q      <= '0;
			sidx_q     <= '0;
			sidx_s1    <= '0;
			sv_s1      <= 1'b0;
			ff_q       <= 1'b0;
			fo_q       <= 1'b0;
			fe_q       <= 1'b0;
			sf_q       <= '0;
			se_q       <= '0;
			ca_q       <= '0;
			ca_s1      <= '0;
			av_s1      <= 1'b0;
			got_q      <= '0;
			fk_q       <= '0;
			fd_q       <= '0;
			fv_s1      <= 1'b0;
			fv_s2      <= 1'b0;
			fc_s2      <= '0;
			ck_q       <= '0;
			ck_s1      <= '0;
			cv_s1      <= 1'b0;
			cm_q       <= CM_NONE;
			tgt_q      <= '0;
			new_id_q   <= '0;
			new_size_q <= '0;
			n_q        <= '0;
			status_q   <= ST_OK;
			first_q    <= '0;
			freed_q    <= '0;
			alloc_ok_q <= 1'b0;
		end else begin
			if (cluster_bytes_we) begin
				cb_q <= cluster_bytes;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end

			if (accept) begin
				ff_q       <= 1'b0;
				fo_q       <= 1'b0;
				fe_q       <= 1'b0;
				n_q        <= '0;
				status_q   <= ST_OK;
				first_q    <= '0;
				freed_q    <= '0;
				alloc_ok_q <= 1'b0;
				cm_q       <= CM_NONE;
			end

			// File table scan: one slot read a cycle, compared in the cycle after its read.
			if (state_q == S_FSCAN) begin
				sv_s1   <= (sidx_q < (SW + 1)'(MAX_FILES));
				sidx_s1 <= sidx_q[SW-1:0];
				sidx_q  <= sidx_q + (SW + 1)'(1);
				if (m_f && !ff_q) begin
					ff_q <= 1'b1;
					sf_q <= sidx_s1;
				end
				if (m_o) begin
					fo_q <= 1'b1;
				end
				if (e_s && !fe_q) begin
					fe_q <= 1'b1;
					se_q <= sidx_s1;
				end
			end else begin
				sv_s1  <= 1'b0;
				sidx_q <= '0;
			end

			if (state_q == S_DECIDE) begin
				status_q   <= dec_status;
				cm_q       <= dec_cm;
				tgt_q      <= dec_tgt;
				new_id_q   <= dec_id;
				new_size_q <= dec_size;
			end

			if (state_q == S_CHECK) begin
				if (chk_fail) begin
					status_q <= chk_status;
				end else begin
					n_q        <= NW'(n_full);
					alloc_ok_q <= 1'b1;
				end
			end

			// First fit scan over the cluster memory.
			if (state_q == S_ALLOC) begin
				ca_q  <= ca_q + CW'(1);
				ca_s1 <= ca_q;
				av_s1 <= 1'b1;
				if (take) begin
					got_q  <= got_q + NW'(1);
					free_q <= free_q - FW'(1);
					if (got_q == '0) begin
						first_q <= ca_s1;
					end
				end
			end else begin
				ca_q  <= '0;
				av_s1 <= 1'b0;
				got_q <= '0;
			end

			// Release of a file's clusters: list read, cluster read, clear.
			if (state_q == S_FREE) begin
				freed_q <= cnt_rd_q;
				fv_s1   <= free_issue;
				fv_s2   <= fv_s1;
				fc_s2   <= list_rd_q;
				if (free_issue) begin
					fk_q <= fk_q + NW'(1);
				end
				if (fv_s2) begin
					fd_q <= fd_q + NW'(1);
					if (used_rd_q) begin
						free_q <= free_q + FW'(1);
					end
				end
			end else begin
				fk_q  <= '0;
				fd_q  <= '0;
				fv_s1 <= 1'b0;
				fv_s2 <= 1'b0;
			end

			// Copy of the scratch list into the file's list.
			if (state_q == S_COPY) begin
				cv_s1 <= copy_issue;
				ck_s1 <= ck_q;
				if (copy_issue) begin
					ck_q <= ck_q + NW'(1);
				end
			end else begin
				ck_q  <= '0;
				cv_s1 <= 1'b0;
			end

			if (state_q == S_COMMIT) begin
				if (cm_q == CM_CREATE) begin
					valid_q[tgt_q] <= 1'b1;
				end else if (cm_q == CM_DELETE) begin
					valid_q[tgt_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			fid_q  <= file_id;
			oid_q  <= other_id;
			size_q <= file_size;
		end
	end

	assign busy               = (state_q != S_IDLE);
	assign done               = (state_q == S_DONE);
	assign status             = status_q;
	assign clusters_allocated = alloc_ok_q ? 7'(n_q) : 7'd0;
	assign first_cluster      = 12'(first_q);
	assign clusters_freed     = 7'(freed_q);
	assign free_clusters      = 13'(free_q);

endmodule

>>> rtl/core/ctfa_div.sv
// ----------------------------------------------------------------------------
// ctfa_div
// Restoring divider, one quotient bit a cycle, rounding the quotient up.
// ----------------------------------------------------------------------------
module ctfa_div import ctfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SIZE_W-1:0] dividend,
	input  logic [DSR_W-1:0]  divisor,
	output logic              done,
	output logic [QN_W-1:0]   clusters
);

	logic [4:0]        cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DSR_W-1:0]  rem_q;
	logic [SIZE_W-1:0] quo_q;
	logic [DSR_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, quo_q[SIZE_W-1]};
	assign ge    = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == 5'd1);
			if (start) begin
				cnt_q <= 5'(SIZE_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[SIZE_W-2:0], ge};
			rem_q <= ge ? DSR_W'(trial - {1'b0, divisor}) : DSR_W'(trial);
		end
	end

	assign done     = done_q;
	assign clusters = {1'b0, quo_q} + QN_W'(rem_q != '0);

endmodule

>>> sim/cluster_table_file_allocator_test.sv
// ----------------------------------------------------------------------------
// cluster_table_file_allocator_test
// Self-checking bench for the FAT style cluster allocator.
// ----------------------------------------------------------------------------
// A queue of transaction beats is filled by the sequencing initial block and
// drained by a falling edge driver. At each rising edge where a beat is
// taken, a shadow copy of the cluster table and the file table predicts the
// result beat. The monitor checks every done beat against the oldest
// prediction. cluster_bytes is rewritten between phases, only after all
// results are in and the block has dropped busy.
// ----------------------------------------------------------------------------
module cluster_table_file_allocator_test import ctfa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCL   = 4096;
	localparam int NFILE = 64;
	localparam int NFCL  = 64;
	localparam logic [15:0] LAST_MARK = 16'hFFFF;
	// The slowest beat is a full first fit scan plus release and copy. This
	// constant is the quiet time allowed after the last result.
	localparam int SETTLE_CYCLES = 4600;
	localparam longint CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic [2:0]  op;
		logic [15:0] fid;
		logic [15:0] oid;
		logic [23:0] size;
		bit          drain;	// wait for all outstanding results first
	} txn_t;

	typedef struct {
		logic [2:0]  status;
		logic [6:0]  alloc;
		logic [11:0] first;
		logic [6:0]  freed;
		logic [12:0] nfree;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        cluster_bytes_we;
	logic [15:0] cluster_bytes;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  operation = '0;
	logic [15:0] file_id = '0;
	logic [15:0] other_id = '0;
	logic [23:0] file_size = '0;
	logic        done;
	logic [2:0]  status;
	logic [6:0]  clusters_allocated;
	logic [11:0] first_cluster;
	logic [6:0]  clusters_freed;
	logic [12:0] free_clusters;

	cluster_table_file_allocator u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cluster_bytes_we  (cluster_bytes_we),
		.cluster_bytes     (cluster_bytes),
		.start             (start),
		.busy              (busy),
		.operation         (operation),
		.file_id           (file_id),
		.other_id          (other_id),
		.file_size         (file_size),
		.done              (done),
		.status            (status),
		.clusters_allocated(clusters_allocated),
		.first_cluster     (first_cluster),
		.clusters_freed    (clusters_freed),
		.free_clusters     (free_clusters)
	);

	txn_t     pending_txns[$];
	outcome_t predicted_outcomes[$];
	int       error_count = 0;
	int       beats_sent = 0;
	int       beats_launched = 0;
	int       results_checked = 0;
	int       send_idle_pct = 16;
	int       plan_cb = 512;	// cluster_bytes the stimulus is currently shaped for
	longint   cycle_count = 0;

	// ------------------------------------------------------------------------
	// Shadow of the block's storage. It is updated in beat order, so it always
	// reflects the state right after the last accepted beat.
	// ------------------------------------------------------------------------
	logic [15:0] sh_ctab [NCL];
	bit          sh_valid [NFILE];
	logic [15:0] sh_ids [NFILE];
	logic [23:0] sh_sizes [NFILE];
	int          sh_count [NFILE];
	int          sh_list [NFILE][NFCL];
	int          grabbed [NFCL];
	logic [15:0] sh_seq;
	int          sh_free;
	logic [15:0] sh_cb;

	task automatic shadow_reset();
		for (int j = 0; j < NCL; j++) sh_ctab[j] = '0;
		for (int s = 0; s < NFILE; s++) begin
			sh_valid[s] = 0;
			sh_ids[s] = '0;
			sh_sizes[s] = '0;
			sh_count[s] = 0;
			for (int k = 0; k < NFCL; k++) sh_list[s][k] = 0;
		end
		// Cluster zero belongs to the reserved file zero; file one is empty.
		sh_ctab[0] = LAST_MARK;
		sh_valid[0] = 1;
		sh_sizes[0] = 24'd512;
		sh_count[0] = 1;
		sh_valid[1] = 1;
		sh_ids[1] = 16'd1;
		sh_seq = 16'd2;
		sh_free = NCL - 1;
		sh_cb = CB_RESET;
	endtask

	function automatic int slot_of(logic [15:0] id);
		for (int s = 0; s < NFILE; s++)
			if (sh_valid[s] && sh_ids[s] == id) return s;
		return -1;
	endfunction

	function automatic int clusters_needed(logic [23:0] size);
		int cb;
		// A zero divisor stands for 65536 bytes per cluster.
		cb = (sh_cb == 0) ? 65536 : int'(sh_cb);
		return (int'(size) + cb - 1) / cb;
	endfunction

	// First fit: the lowest free clusters, ascending; the last gets the end mark.
	task automatic grab_clusters(int n);
		int got;
		got = 0;
		for (int j = 0; j < NCL && got < n; j++) begin
			if (sh_ctab[j] != 0) continue;
			sh_ctab[j] = (got + 1 == n) ? LAST_MARK : sh_seq;
			sh_seq = sh_seq + 16'd1;
			// The sequence number never lands on zero or on the end mark.
			if (sh_seq == 16'd0 || sh_seq == LAST_MARK) sh_seq = 16'd1;
			grabbed[got] = j;
			got++;
		end
		sh_free -= got;
	endtask

	function automatic int release_clusters(int s);
		int n;
		n = sh_count[s];
		for (int k = 0; k < n && k < NFCL; k++) begin
			if (sh_ctab[sh_list[s][k]] != 0) begin
				sh_ctab[sh_list[s][k]] = '0;
				sh_free++;
			end
		end
		sh_count[s] = 0;
		return n;
	endfunction

	task automatic create_file(logic [15:0] id, logic [23:0] size, inout outcome_t res);
		int n;
		int s;
		s = -1;
		if (slot_of(id) >= 0) begin
			res.status = ST_EXISTS;
			return;
		end
		n = clusters_needed(size);
		if (n > NFCL) begin
			res.status = ST_LARGE;
			return;
		end
		for (int k = NFILE - 1; k >= 0; k--) if (!sh_valid[k]) s = k;
		if (s < 0) begin
			res.status = ST_FULL;
			return;
		end
		if (n > sh_free) begin
			res.status = ST_NOSPACE;
			return;
		end
		grab_clusters(n);
		for (int k = 0; k < n; k++) sh_list[s][k] = grabbed[k];
		sh_valid[s] = 1;
		sh_ids[s] = id;
		sh_sizes[s] = size;
		sh_count[s] = n;
		res.alloc = 7'(n);
		res.first = (n != 0) ? 12'(grabbed[0]) : '0;
	endtask

	task automatic predict_txn(txn_t t, output outcome_t res);
		int s;
		int n;
		res = '{status: ST_OK, alloc: '0, first: '0, freed: '0, nfree: '0};
		s = slot_of(t.fid);
		case (t.op)
			OP_NEW: begin
				create_file(t.fid, t.size, res);
			end
			OP_DELETE: begin
				if (s < 0) begin
					res.status = ST_MISSING;
				end else begin
					res.freed = 7'(release_clusters(s));
					sh_valid[s] = 0;
				end
			end
			OP_COPY, OP_RENAME: begin
				// An existing target wins over a missing source.
				if (slot_of(t.oid) >= 0) res.status = ST_TARGET;
				else if (s < 0) res.status = ST_MISSING;
				else if (t.op == OP_COPY) create_file(t.oid, sh_sizes[s], res);
				else sh_ids[s] = t.oid;
			end
			OP_MODIFY: begin
				if (s < 0) begin
					create_file(t.fid, t.size, res);
				end else begin
					// The new clusters are counted while the old ones are held.
					n = clusters_needed(t.size);
					if (n > NFCL) begin
						res.status = ST_LARGE;
					end else if (n > sh_free) begin
						res.status = ST_NOSPACE;
					end else begin
						grab_clusters(n);
						res.freed = 7'(release_clusters(s));
						for (int k = 0; k < n; k++) sh_list[s][k] = grabbed[k];
						sh_count[s] = n;
						sh_sizes[s] = t.size;
						res.alloc = 7'(n);
						res.first = (n != 0) ? 12'(grabbed[0]) : '0;
					end
				end
			end
			default: ;	// unused codes leave everything alone
		endcase
		res.nfree = 13'(sh_free);
	endtask

	// ------------------------------------------------------------------------
	// Clock.
	// ------------------------------------------------------------------------
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Driver: a beat stays on the ports until taken; the next one is launched
	// unless the sender idles this cycle or a drain beat waits for results. A
	// beat counts as taken once the monitor has seen as many as were launched.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		txn_t t;
		logic nxt_start;
		nxt_start = start;
		if (arst_n && !(start && beats_sent != beats_launched)) begin
			nxt_start = 0;
			if (pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct &&
			    !(pending_txns[0].drain && (predicted_outcomes.size() != 0 || busy))) begin
				t = pending_txns.pop_front();
				operation <= t.op;
				file_id <= t.fid;
				other_id <= t.oid;
				file_size <= t.size;
				nxt_start = 1;
				beats_launched++;
			end
		end
		start <= nxt_start;
	end

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on result %0d: %s is %0d, predicted %0d",
		         results_checked, field, got, want);
		error_count++;
	endtask

	// ------------------------------------------------------------------------
	// Monitor and predictor. A done beat is checked before a beat taken at the
	// same edge is predicted, which keeps the shadow in step with the block.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		outcome_t want;
		txn_t t;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[cluster_table_file_allocator] ERROR");
			$finish;
		end
		if (arst_n) begin
			if (done) begin
				if (predicted_outcomes.size() == 0) begin
					report_mismatch("result beats outstanding", 0, 1);
				end else begin
					want = predicted_outcomes.pop_front();
					if (status !== want.status) report_mismatch("status", status, want.status);
					if (clusters_allocated !== want.alloc)
						report_mismatch("clusters_allocated", clusters_allocated, want.alloc);
					if (first_cluster !== want.first)
						report_mismatch("first_cluster", first_cluster, want.first);
					if (clusters_freed !== want.freed)
						report_mismatch("clusters_freed", clusters_freed, want.freed);
					if (free_clusters !== want.nfree)
						report_mismatch("free_clusters", free_clusters, want.nfree);
					results_checked++;
				end
			end
			if (cluster_bytes_we) sh_cb = cluster_bytes;
			if (start && !busy) begin
				t = '{op: operation, fid: file_id, oid: other_id, size: file_size, drain: 0};
				predict_txn(t, want);
				predicted_outcomes.insert(predicted_outcomes.size(), want);
				beats_sent++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic queue_txn(logic [2:0] op, logic [15:0] fid, logic [15:0] oid,
	                         logic [23:0] size, bit drain = 0);
		txn_t t;
		t = '{op: op, fid: fid, oid: oid, size: size, drain: drain};
		pending_txns.insert(pending_txns.size(), t);
	endtask

	function automatic logic [15:0] pick_id();
		// A small pool of ids keeps hits on existing files frequent.
		if ($urandom_range(99) < 85) return 16'($urandom_range(19));
		return 16'($urandom);
	endfunction

	function automatic logic [23:0] pick_size();
		longint cbe;
		longint n;
		longint sz;
		if ($urandom_range(99) >= 85) return 24'($urandom);
		cbe = (plan_cb == 0) ? 65536 : plan_cb;
		n = $urandom_range(66);
		if (n == 0) return '0;
		sz = (n - 1) * cbe + $urandom_range(int'(cbe - 1)) + 1;
		return (sz > 24'hFFFFFF) ? 24'hFFFFFF : 24'(sz);
	endfunction

	task automatic queue_random(int count);
		int w;
		logic [2:0] op;
		for (int i = 0; i < count; i++) begin
			w = $urandom_range(99);
			if (w < 30) op = OP_NEW;
			else if (w < 50) op = OP_DELETE;
			else if (w < 62) op = OP_COPY;
			else if (w < 72) op = OP_RENAME;
			else if (w < 95) op = OP_MODIFY;
			else op = 3'($urandom_range(7, 5));
			queue_txn(op, pick_id(), pick_id(), pick_size(), $urandom_range(99) < 8);
		end
	endtask

	// Waits until every beat has been sent and answered, then stays quiet for
	// the longest latency so a stray result would still be caught.
	task automatic wait_quiet();
		do @(posedge clk);
		while (pending_txns.size() != 0 || start || predicted_outcomes.size() != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cluster_bytes(int value);
		@(negedge clk);
		cluster_bytes <= 16'(value);
		cluster_bytes_we <= 1;
		@(negedge clk);
		cluster_bytes_we <= 0;
		plan_cb = value;
	endtask

	// ------------------------------------------------------------------------
	// Sequencing.
	// ------------------------------------------------------------------------
	initial begin
		shadow_reset();
		arst_n = 0;
		cluster_bytes_we = 0;
		cluster_bytes = CB_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed beats at the reset cluster size of 512 bytes.
		queue_txn(OP_NEW, 16'd5, 16'd0, 24'd0);          // zero size
		queue_txn(OP_NEW, 16'd5, 16'd0, 24'd100);        // duplicate id
		queue_txn(OP_NEW, 16'd6, 16'd0, 24'd32768);      // exactly the largest file
		queue_txn(OP_NEW, 16'd7, 16'd0, 24'd32769);      // one byte over
		queue_txn(OP_NEW, 16'd8, 16'd0, 24'hFFFFFF);
		queue_txn(OP_COPY, 16'd6, 16'd9, 24'd0);
		queue_txn(OP_COPY, 16'd6, 16'd9, 24'd0);         // target exists
		queue_txn(OP_COPY, 16'd9, 16'd9, 24'd0);         // copy onto itself
		queue_txn(OP_COPY, 16'd77, 16'd9, 24'd0);        // target wins over missing source
		queue_txn(OP_COPY, 16'd77, 16'd78, 24'd0, 1);    // missing source
		queue_txn(OP_RENAME, 16'd9, 16'd10, 24'd0);
		queue_txn(OP_RENAME, 16'd9, 16'd11, 24'd0);
		queue_txn(OP_RENAME, 16'd10, 16'd0, 24'd0);
		queue_txn(OP_MODIFY, 16'd10, 16'd0, 24'd1000);
		queue_txn(OP_MODIFY, 16'd200, 16'd0, 24'd700);   // missing file is created
		queue_txn(OP_MODIFY, 16'd10, 16'd0, 24'hFFFFFF);
		queue_txn(OP_DELETE, 16'd6, 16'd0, 24'd0);
		queue_txn(OP_DELETE, 16'd6, 16'd0, 24'd0);
		queue_txn(OP_DELETE, 16'd0, 16'd0, 24'd0);       // reserved file zero
		queue_txn(3'd5, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		queue_txn(3'd7, 16'd3, 16'd4, 24'd5);
		queue_txn(OP_NEW, 16'hFFFF, 16'hFFFF, 24'd1);
		queue_txn(OP_MODIFY, 16'd1, 16'd0, 24'd513);     // reserved empty file grows
		queue_txn(OP_NEW, 16'd6, 16'd0, 24'd1);          // reuses freed clusters
		wait_quiet();

		// One byte clusters: counts follow the size byte for byte.
		write_cluster_bytes(1);
		queue_random(15);
		wait_quiet();

		send_idle_pct = 78;
		write_cluster_bytes(65535);
		queue_random(10);
		wait_quiet();

		write_cluster_bytes(0);
		queue_random(10);
		wait_quiet();

		// Fill the store with the largest files until the file table and the
		// cluster table run out, then grow and delete files at the edge.
		send_idle_pct = 0;
		write_cluster_bytes(512);
		for (int i = 0; i < 64; i++) queue_txn(OP_NEW, 16'(1000 + i), 16'd0, 24'd32768);
		queue_txn(OP_MODIFY, 16'd1, 16'd0, 24'd32768);
		queue_txn(OP_MODIFY, 16'd1000, 16'd0, 24'd32768);
		queue_txn(OP_MODIFY, 16'd1001, 16'd0, 24'd32768, 1);
		for (int i = 0; i < 8; i++) queue_txn(OP_DELETE, 16'(1002 + i), 16'd0, 24'd0);
		queue_random(5);
		wait_quiet();

		write_cluster_bytes($urandom_range(65535, 1));
		queue_random(5);
		wait_quiet();

		$display("%0d transaction beats sent, %0d results checked", beats_sent, results_checked);
		$display("cluster sizes 512, 1, 65535, 65536 and random, store filled to capacity");
		if (error_count == 0) begin
			$display("[cluster_table_file_allocator] OK");
		end else begin
			$display("[cluster_table_file_allocator] ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/ctfa_pkg.sv
rtl/core/ctfa_div.sv
rtl/core/cluster_table_file_allocator.sv
sim/cluster_table_file_allocator_test.sv
